// ===== rtl/core/xor_base64_codec_defines.svh =====
// ----------------------------------------------------------------------------
// xor_base64_codec_defines.svh
// Assertion macros shared by the checker of the XOR/base64 codec.
// ----------------------------------------------------------------------------
`ifndef XOR_BASE64_CODEC_DEFINES_SVH
`define XOR_BASE64_CODEC_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define XB64_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define XB64_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/xb64_pkg.sv =====
// ----------------------------------------------------------------------------
// xb64_pkg
// Types, register indexes and character helpers of the XOR/base64 codec.
// ----------------------------------------------------------------------------
`default_nettype none

package xb64_pkg;

    localparam int KEY_WORDS = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_DIRECTION = 3'd0;
    localparam logic [2:0] REG_KEY_WORD0 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD1 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD2 = 3'd3;
    localparam logic [2:0] REG_KEY_WORD3 = 3'd4;

    // Direction codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic                               direction;
        logic                               clear;
        logic [KEY_WORDS-1:0][63:0]         key;
    } cfg_t;

    // One group of up to four result items.
    typedef struct packed {
        logic [2:0]                         count;
        logic [3:0][7:0]                    data;
        logic                               last;
        logic                               bad;
    } grp_t;

    // Sextet value to its base64 character.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'h41;
        end
        if (v < 6'd52) begin
            return w + 8'h47;
        end
        if (v < 6'd62) begin
            return w - 8'd4;
        end
        if (v == 6'd62) begin
            return 8'h2B;
        end
        return 8'h2F;
    endfunction

    // Character to {valid, sextet}; valid is low outside the alphabet.
    function automatic logic [6:0] b64_sextet(input logic [7:0] c);
        logic [7:0] w;
        w = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            w = c - 8'h41;
            return {1'b1, w[5:0]};
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            w = c - 8'h47;
            return {1'b1, w[5:0]};
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            w = c + 8'd4;
            return {1'b1, w[5:0]};
        end
        if (c == 8'h2B) begin
            return {1'b1, 6'd62};
        end
        if (c == 8'h2F) begin
            return {1'b1, 6'd63};
        end
        return {1'b0, w[5:0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xb64_cfg.sv =====
// ----------------------------------------------------------------------------
// xb64_cfg
// Configuration registers: direction and the four key words.
// ----------------------------------------------------------------------------
`default_nettype none

module xb64_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    output xb64_pkg::cfg_t           cfg
);
    import xb64_pkg::*;

    logic                           dir_reg;
    logic                           dir_next;
    logic [KEY_WORDS-1:0][63:0]     key_reg;
    logic [KEY_WORDS-1:0][63:0]     key_next;
    logic                           dir_write;

    assign cfg_ready = 1'b1;
    assign dir_write = cfg_valid && (cfg_index == REG_DIRECTION);

    always_comb
    begin
        dir_next = dir_reg;
        key_next = key_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DIRECTION: dir_next    = cfg_data[0];
                REG_KEY_WORD0: key_next[0] = cfg_data;
                REG_KEY_WORD1: key_next[1] = cfg_data;
                REG_KEY_WORD2: key_next[2] = cfg_data;
                REG_KEY_WORD3: key_next[3] = cfg_data;
                default:       dir_next    = dir_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_ENCODE;
            key_reg <= '0;
        end
        else
        begin
            dir_reg <= dir_next;
            key_reg <= key_next;
        end
    end

    // A direction write restarts the message state in the same edge.
    assign cfg.direction = dir_reg;
    assign cfg.clear     = dir_write;
    assign cfg.key       = key_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xb64_step.sv =====
// ----------------------------------------------------------------------------
// xb64_step
// Input register, message state and the per-item encode/decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

module xb64_step #(
    parameter int KEY_BYTES = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,
    input  wire logic                s_tlast,
    input  wire xb64_pkg::cfg_t      cfg,
    input  wire logic                out_free,
    output logic                     push,
    output xb64_pkg::grp_t           grp
);
    import xb64_pkg::*;

    localparam int KP_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    function automatic logic [KP_W-1:0] kp_inc(input logic [KP_W-1:0] p);
        if (p == KP_W'(KEY_BYTES - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    logic [7:0]         key_byte [KEY_BYTES];

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         in_data_reg;
    logic               in_last_reg;

    logic [23:0]        bits_reg;
    logic [23:0]        bits_next;
    logic [1:0]         fill_reg;
    logic [1:0]         fill_next;
    logic [1:0]         pad_reg;
    logic [1:0]         pad_next;
    logic [KP_W-1:0]    kp_reg;
    logic [KP_W-1:0]    kp_next;
    logic               bad_reg;
    logic               bad_next;

    logic [KP_W-1:0]    kp1;
    logic [KP_W-1:0]    kp2;
    logic [KP_W-1:0]    kp3;
    logic [1:0]         f_enc;
    logic [7:0]         xbyte;
    logic [23:0]        base;
    logic [2:0]         fill1;
    logic [2:0]         pads;
    logic [6:0]         sx;
    logic [5:0]         v;
    logic [1:0]         pad_new;
    logic               bad_new;
    logic               consume;
    grp_t               res;

    for (genvar gi = 0; gi < KEY_BYTES; gi++)
    begin : g_key
        localparam int WRD = gi / 8;
        localparam int OFS = (gi % 8) * 8;
        assign key_byte[gi] = cfg.key[WRD][OFS +: 8];
    end

    always_comb
    begin
        kp1       = kp_inc(kp_reg);
        kp2       = kp_inc(kp1);
        kp3       = kp_inc(kp2);
        f_enc     = (fill_reg == 2'd3) ? 2'd0 : fill_reg;
        xbyte     = in_data_reg ^ key_byte[kp_reg];
        base      = '0;
        fill1     = '0;
        pads      = '0;
        sx        = b64_sextet(in_data_reg);
        v         = '0;
        pad_new   = pad_reg;
        bad_new   = bad_reg;
        bits_next = bits_reg;
        fill_next = fill_reg;
        pad_next  = pad_reg;
        kp_next   = kp_reg;
        bad_next  = bad_reg;
        res       = '0;
        res.last  = in_last_reg;

        if (cfg.direction == DIR_ENCODE)
        begin
            base = (f_enc == 2'd0) ? 24'd0 : bits_reg;
            case (f_enc)
                2'd0:    base[23:16] = base[23:16] | xbyte;
                2'd1:    base[15:8]  = base[15:8]  | xbyte;
                default: base[7:0]   = base[7:0]   | xbyte;
            endcase
            fill1 = {1'b0, f_enc} + 3'd1;
            if (fill1 == 3'd3 || in_last_reg)
            begin
                // Characters past the filled bytes become padding.
                for (int j = 0; j < 4; j++)
                begin
                    if (3'(j) < fill1 + 3'd1)
                    begin
                        res.data[j] = b64_char(base[18 - 6 * j +: 6]);
                    end
                    else
                    begin
                        res.data[j] = CHAR_PAD;
                    end
                end
                res.count = 3'd4;
                bits_next = '0;
                fill_next = '0;
                pad_next  = '0;
                kp_next   = in_last_reg ? '0 : kp1;
                bad_next  = in_last_reg ? 1'b0 : bad_reg;
            end
            else
            begin
                bits_next = base;
                fill_next = fill1[1:0];
                kp_next   = kp1;
            end
        end
        else
        begin
            if (in_data_reg == CHAR_PAD)
            begin
                if (pad_reg != 2'd3)
                begin
                    pad_new = pad_reg + 2'd1;
                end
            end
            else if (!sx[6])
            begin
                bad_new = 1'b1;
            end
            else
            begin
                v = sx[5:0];
            end

            base = (fill_reg == 2'd0) ? 24'd0 : bits_reg;
            case (fill_reg)
                2'd0:    base[23:18] = base[23:18] | v;
                2'd1:    base[17:12] = base[17:12] | v;
                2'd2:    base[11:6]  = base[11:6]  | v;
                default: base[5:0]   = base[5:0]   | v;
            endcase
            fill1 = {1'b0, fill_reg} + 3'd1;

            if (fill1 == 3'd4 || in_last_reg)
            begin
                // Missing characters of a short group count as padding.
                pads        = {1'b0, pad_new} + (3'd4 - fill1);
                res.count   = (pads >= 3'd3) ? 3'd0 : (3'd3 - pads);
                res.data[0] = base[23:16] ^ key_byte[kp_reg];
                res.data[1] = base[15:8]  ^ key_byte[kp1];
                res.data[2] = base[7:0]   ^ key_byte[kp2];
                res.bad     = bad_new;
                bits_next   = '0;
                fill_next   = '0;
                pad_next    = '0;
                if (in_last_reg)
                begin
                    kp_next  = '0;
                    bad_next = 1'b0;
                end
                else
                begin
                    case (res.count)
                        3'd0:    kp_next = kp_reg;
                        3'd1:    kp_next = kp1;
                        3'd2:    kp_next = kp2;
                        default: kp_next = kp3;
                    endcase
                    bad_next = bad_new;
                end
            end
            else
            begin
                bits_next = base;
                fill_next = fill1[1:0];
                pad_next  = pad_new;
                bad_next  = bad_new;
            end
        end
    end

    // An item that yields nothing never waits on the output side.
    assign consume  = in_valid_reg && ((res.count == 3'd0) || out_free);
    assign push     = consume && (res.count != 3'd0);
    assign grp      = res;
    assign s_tready = !in_valid_reg || consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            bits_reg     <= '0;
            fill_reg     <= '0;
            pad_reg      <= '0;
            kp_reg       <= '0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg.clear)
            begin
                bits_reg <= '0;
                fill_reg <= '0;
                pad_reg  <= '0;
                kp_reg   <= '0;
                bad_reg  <= 1'b0;
            end
            else if (consume)
            begin
                bits_reg <= bits_next;
                fill_reg <= fill_next;
                pad_reg  <= pad_next;
                kp_reg   <= kp_next;
                bad_reg  <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/xb64_out.sv =====
// ----------------------------------------------------------------------------
// xb64_out
// Result group register that hands out its items one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module xb64_out (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire xb64_pkg::grp_t      grp,
    output logic                     out_free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,
    output logic                     m_tlast,
    output logic                     m_tuser
);
    import xb64_pkg::*;

    grp_t           grp_reg;
    logic           busy_reg;
    logic           busy_next;
    logic [1:0]     idx_reg;
    logic [1:0]     idx_next;
    logic           take;
    logic           at_final;

    assign take     = busy_reg && m_tready;
    assign at_final = ({1'b0, idx_reg} == (grp_reg.count - 3'd1));
    assign out_free = !busy_reg || (take && at_final);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (push)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (take)
        begin
            if (at_final)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            grp_reg <= grp;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = grp_reg.data[idx_reg];
    assign m_tlast  = grp_reg.last && at_final;
    assign m_tuser  = grp_reg.bad;

endmodule

`default_nettype wire

// ===== rtl/core/xor_base64_codec.sv =====
// ----------------------------------------------------------------------------
// xor_base64_codec
// Stream codec: repeating-key XOR combined with standard base64.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Carries
//   s_*       s_tvalid / s_tready   data_in in s_tdata, in_last in s_tlast
//   m_*       m_tvalid / m_tready   data_out in m_tdata, out_last in m_tlast,
//                                   bad_char in m_tuser
//   cfg_*     cfg_valid / cfg_ready register index and 64-bit write data
//
// An accepted item waits in the input register, where the encode or decode
// logic updates the message state and builds a group of up to four result
// items into the group register. The group register hands out one item per
// cycle while m_tready is high, so the output port sets the rate: encoding
// gives four characters per three bytes, decoding up to three bytes per four
// characters. An item that yields no result is taken while a group still
// drains; one that yields results waits until the last item of the current
// group is taken. Reset is asynchronous and clears all control state; there
// is no clearing pass, the block takes items as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_base64_codec #(
    parameter int KEY_BYTES = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // Input items.
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,    // [7:0] data_in
    input  wire logic           s_tlast,    // in_last
    // Result items.
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,    // [7:0] data_out
    output logic                m_tlast,    // out_last
    output logic                m_tuser,    // [0] bad_char
    // Configuration writes.
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [63:0]    cfg_data
);
    import xb64_pkg::*;

    cfg_t   cfg;
    grp_t   grp;
    logic   push;
    logic   out_free;

    // Direction and key registers. Writing the direction restarts the message.
    xb64_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg)
    );

    // Input register plus the per-item XOR and base64 logic.
    xb64_step #(
        .KEY_BYTES  (KEY_BYTES)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg        (cfg),
        .out_free   (out_free),
        .push       (push),
        .grp        (grp)
    );

    // Group register that serializes the result items.
    xb64_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .grp        (grp),
        .out_free   (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/xb64_checker.sv =====
// ----------------------------------------------------------------------------
// xb64_checker
// Port-level assertions of the XOR/base64 codec, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xor_base64_codec_defines.svh"

module xb64_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    input  wire logic           s_tready,
    input  wire logic           m_tvalid,
    input  wire logic           m_tready,
    input  wire logic [7:0]     m_tdata,
    input  wire logic           m_tlast,
    input  wire logic           m_tuser
);

    // With no group draining, the input register can always move on.
    `XB64_ASSERT_IMP(a_idle_ready, !m_tvalid, s_tready, "input stalled with output idle")

    // A new group shows up after the item that made it passes the input register and the group register.
    `XB64_ASSERT_IMP(a_group_origin, $rose(m_tvalid), $past(s_tvalid && s_tready, 2),
        "result appeared without a matching input item")

    // A stalled result item holds.
    `XB64_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "result item changed while stalled")

endmodule

bind xor_base64_codec xb64_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the XOR/base64 stream codec.
//
// Items are pushed through the slave stream port while a predictor inside the
// testbench follows the codec's message state (group bits, fill, pad count,
// key position and the sticky bad-character flag) and queues every result
// item it expects. A checker compares each item taken from the master port
// with the oldest queued result, field by field. Directed tests cover group
// packing, padding, short message ends, bad characters and register side
// effects; random tests then run mostly well-formed messages in both
// directions under random stalls, a long output hold-off and a quiet final
// burst.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import xb64_pkg::*;

    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 100000;
    // Cycles allowed after the last expected result before the block counts
    // as idle: time for the input register and to build the group, plus margin.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 80;

    // One result item as seen on the master port.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } codec_out_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;     // [7:0] data_in
    logic        s_tlast   = 1'b0;      // in_last
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;               // [7:0] data_out
    logic        m_tlast;               // out_last
    logic        m_tuser;               // [0] bad_char
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_DIRECTION;
    logic [63:0] cfg_data  = 64'h0;

    always #(CLK_HALF_NS) clk = ~clk;

    xor_base64_codec #(
        .KEY_BYTES (32)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the registers and message state.
    // ------------------------------------------------------------------------
    logic        cur_dir;
    logic [63:0] key_reg [4];
    logic [23:0] grp_bits;
    int unsigned grp_fill;
    int unsigned pad_cnt;
    logic [4:0]  key_pos;
    logic        bad_seen;

    codec_out_t  codec_out_q [$];

    // Knobs shared by the stimulus, the receiver and the run summary.
    bit          tx_idle_en      = 1'b1;
    bit          rx_idle_en      = 1'b1;
    int          rx_hold_cycles  = 0;
    int          err_cnt         = 0;
    int          items_sent      = 0;
    int          msgs_sent       = 0;
    int          results_seen    = 0;
    int          bad_results     = 0;
    int          cfg_writes      = 0;
    int          cycle_cnt       = 0;

    // Sextet value to its base64 character.
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        if (v < 6'd26) begin
            return 8'h41 + 8'(v);             // 'A'..'Z'
        end
        else if (v < 6'd52) begin
            return 8'h61 + 8'(v - 6'd26);     // 'a'..'z'
        end
        else if (v < 6'd62) begin
            return 8'h30 + 8'(v - 6'd52);     // '0'..'9'
        end
        else if (v == 6'd62) begin
            return 8'h2B;                     // '+'
        end
        return 8'h2F;                         // '/'
    endfunction

    // Base64 character to its sextet, or -1 outside the alphabet.
    function automatic int char_to_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return int'(c - 8'h41);
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            return int'(c - 8'h61) + 26;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            return int'(c - 8'h30) + 52;
        end
        if (c == 8'h2B) begin
            return 62;
        end
        if (c == 8'h2F) begin
            return 63;
        end
        return -1;
    endfunction

    // The key byte at the current position; the position wraps after 32.
    function automatic logic [7:0] take_key_byte();
        logic [7:0] kb;
        kb = key_reg[key_pos[4:3]][key_pos[2:0]*8 +: 8];
        key_pos = key_pos + 5'd1;
        return kb;
    endfunction

    function automatic void clear_group_state();
        grp_bits = '0;
        grp_fill = 0;
        pad_cnt  = 0;
    endfunction

    function automatic void clear_message_state();
        clear_group_state();
        key_pos  = '0;
        bad_seen = 1'b0;
    endfunction

    function automatic void apply_reg_write(input logic [2:0] idx, input logic [63:0] val);
        if (idx == REG_DIRECTION) begin
            cur_dir = val[0];
            clear_message_state();
        end
        else if (idx >= REG_KEY_WORD0 && idx <= REG_KEY_WORD3) begin
            key_reg[idx - REG_KEY_WORD0] = val;
        end
    endfunction

    // Work out the result items that one accepted input item causes and queue
    // them in order.
    function automatic void predict_codec_step(input logic [7:0] din, input logic lst);
        codec_out_t  res;
        int unsigned fill;
        int unsigned pads;
        int unsigned nbytes;
        int          sx;
        logic [23:0] v;
        logic [7:0]  b;
        fill = grp_fill;
        if (cur_dir == DIR_ENCODE) begin
            if (fill == 0) begin
                grp_bits = '0;
            end
            grp_bits = grp_bits | (24'(din ^ take_key_byte()) << (16 - 8 * fill));
            fill++;
            if (fill < 3 && !lst) begin
                grp_fill = fill;
                return;
            end
            // fill bytes give fill+1 characters; the rest of the four are pads.
            for (int j = 0; j < 4; j++) begin
                res.data = (j < fill + 1) ? sextet_to_char(6'(grp_bits >> (18 - 6 * j)))
                                          : CHAR_PAD;
                res.last = lst && (j == 3);
                res.bad  = 1'b0;
                codec_out_q.push_back(res);
            end
        end
        else begin
            if (din == CHAR_PAD) begin
                v = '0;
                if (pad_cnt < 3) begin
                    pad_cnt++;
                end
            end
            else begin
                sx = char_to_sextet(din);
                if (sx < 0) begin
                    v = '0;
                    bad_seen = 1'b1;
                end
                else begin
                    v = 24'(sx);
                end
            end
            if (fill == 0) begin
                grp_bits = '0;
            end
            grp_bits = grp_bits | (v << (18 - 6 * fill));
            fill++;
            if (fill < 4 && !lst) begin
                grp_fill = fill;
                return;
            end
            // Characters missing at a short message end count as pads.
            pads   = pad_cnt + (4 - fill);
            nbytes = (pads >= 3) ? 0 : 3 - pads;
            for (int j = 0; j < nbytes; j++) begin
                b = 8'(grp_bits >> (16 - 8 * j));
                res.data = b ^ take_key_byte();
                res.last = lst && (j + 1 == nbytes);
                res.bad  = bad_seen;
                codec_out_q.push_back(res);
            end
        end
        if (lst) begin
            clear_message_state();
        end
        else begin
            clear_group_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every item taken from the master port is compared with
    // the oldest expected result. Handshake signals are sampled at the edge,
    // before any update of that edge lands.
    // ------------------------------------------------------------------------
    codec_out_t want;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser) begin
                bad_results++;
            end
            if (codec_out_q.size() == 0) begin
                $display("%0t: unexpected result item data_out=%h out_last=%b bad_char=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                err_cnt++;
            end
            else begin
                want = codec_out_q.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: data_out expected %h actual %h", $time, want.data, m_tdata);
                    err_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: out_last expected %b actual %b", $time, want.last, m_tlast);
                    err_cnt++;
                end
                if (m_tuser !== want.bad) begin
                    $display("%0t: bad_char expected %b actual %b", $time, want.bad, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver: random stall bursts, or one long hold-off when a test asks
    // for it. At most one assignment to m_tready per clock edge.
    initial begin
        forever begin
            @(posedge clk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                m_tready <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d result items still expected",
                     $time, codec_out_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks. All of them start and end on a rising edge.
    // ------------------------------------------------------------------------

    // Offer one item and return at the edge where it is accepted. Valid is
    // left high, so items run back to back unless tx_idle_en adds an idle gap.
    task automatic send_item(input logic [7:0] din, input logic lst);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= din;
        s_tlast  <= lst;
        do begin
            @(posedge clk);
        end while (!s_tready);
        predict_codec_step(din, lst);
        items_sent++;
        if (lst) begin
            msgs_sent++;
        end
    endtask

    task automatic send_text(input string txt, input bit end_msg);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(txt[i], end_msg && (i == txt.len() - 1));
        end
    endtask

    // Stop sending and wait until every expected result has come out, then
    // give the block time to settle items that cause no result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (codec_out_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg_write(idx, val);
        cfg_writes++;
        // A quiet edge follows so valid is never lowered and raised in one step.
        @(posedge clk);
    endtask

    function automatic logic [63:0] random_key_word();
        case ($urandom_range(0, 5))
            0:       return 64'h0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic load_random_key();
        write_reg(REG_KEY_WORD0, random_key_word());
        write_reg(REG_KEY_WORD1, random_key_word());
        write_reg(REG_KEY_WORD2, random_key_word());
        write_reg(REG_KEY_WORD3, random_key_word());
    endtask

    // Direction writes carry random upper bits; only bit 0 counts.
    task automatic set_direction(input logic dir);
        write_reg(REG_DIRECTION, {$urandom(), 31'($urandom()), dir});
    endtask

    // Random plaintext message; now and then longer than the key so the key
    // position wraps.
    task automatic send_plain_message();
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            send_item(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Mostly alphabet characters; one in ten is an arbitrary byte, which may be
    // a pad or a character outside the alphabet.
    function automatic logic [7:0] pick_b64_char();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return sextet_to_char(6'($urandom_range(0, 63)));
    endfunction

    // Random base64 message: full groups, and a final group that is full,
    // padded, or cut short by the message end.
    task automatic send_b64_message();
        int         groups;
        int         n;
        logic [7:0] grp [4];
        groups = $urandom_range(1, 4);
        for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 4; k++) begin
                grp[k] = pick_b64_char();
            end
            n = 4;
            if (g == groups - 1) begin
                case ($urandom_range(0, 5))
                    1: grp[3] = CHAR_PAD;
                    2: begin
                        grp[2] = CHAR_PAD;
                        grp[3] = CHAR_PAD;
                    end
                    3: n = 3;
                    4: n = 2;
                    5: n = 1;
                    default: n = 4;
                endcase
            end
            for (int k = 0; k < n; k++) begin
                send_item(grp[k], (g == groups - 1) && (k == n - 1));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Encode with the all-zero key from reset: one, two and four byte
    // messages, so both padded partial groups and a full group appear.
    task automatic test_encode_groups();
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h4D, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h6E, 1'b0);
        send_item(8'h80, 1'b1);
        drain_results();
    endtask

    // Extreme and byte-distinct key words; the short message uses key bytes of word 0 only.
    task automatic test_encode_key();
        write_reg(REG_KEY_WORD0, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_KEY_WORD1, 64'h0);
        write_reg(REG_KEY_WORD2, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_KEY_WORD3, 64'h8000_0000_0000_0001);
        send_item(8'h00, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'hFF, 1'b1);
        drain_results();
    endtask

    // A key write mid-message keeps the partial group and the key position; a
    // direction write throws both away. Writes to unused indexes change nothing.
    task automatic test_config_side_effects();
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        drain_results();
        write_reg(REG_KEY_WORD0, 64'h0F0E_0D0C_0B0A_0908);
        send_item(8'h56, 1'b1);
        drain_results();
        send_item(8'h78, 1'b0);
        send_item(8'h9A, 1'b0);
        drain_results();
        set_direction(DIR_ENCODE);
        for (int k = 1; k <= 3; k++) begin
            write_reg(REG_KEY_WORD3 + 3'(k), {$urandom(), $urandom()});
        end
        send_item(8'hBC, 1'b1);
        drain_results();
    endtask

    // Decode: full groups across the alphabet, pads anywhere in a group, a
    // group with three pads that gives nothing, a short end and a bad character.
    task automatic test_decode_groups();
        write_reg(REG_DIRECTION, 64'hFFFF_FFFF_FFFF_FFFF);
        send_text("z9+/TQ==", 1'b1);
        send_text("=A==", 1'b1);
        drain_results();
        send_text("TW", 1'b1);
        send_text("T*", 1'b1);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items back to back, so the codec fills up and stalls its input.
    // The message is longer than the key, so the key position wraps.
    task automatic test_output_backpressure();
        set_direction(DIR_ENCODE);
        load_random_key();
        tx_idle_en = 1'b0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 34; i++) begin
            send_item(8'($urandom_range(0, 255)), i == 33);
        end
        // The sender now pauses until every result has come out.
        drain_results();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_encode();
        int start;
        set_direction(DIR_ENCODE);
        for (int s = 0; s < 2; s++) begin
            load_random_key();
            start = items_sent;
            while (items_sent - start < 6) begin
                send_plain_message();
            end
            drain_results();
        end
    endtask

    task automatic test_random_decode();
        int start;
        set_direction(DIR_DECODE);
        for (int s = 0; s < 2; s++) begin
            load_random_key();
            start = items_sent;
            while (items_sent - start < 6) begin
                send_b64_message();
            end
            drain_results();
        end
    endtask

    // Final stretch with no idling on either side, both directions.
    task automatic test_full_rate();
        int start;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_direction(DIR_ENCODE);
        start = items_sent;
        while (items_sent - start < 6) begin
            send_plain_message();
        end
        drain_results();
        set_direction(DIR_DECODE);
        start = items_sent;
        while (items_sent - start < 6) begin
            send_b64_message();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        cur_dir = DIR_ENCODE;
        for (int k = 0; k < KEY_WORDS; k++) begin
            key_reg[k] = 64'h0;
        end
        clear_message_state();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_groups();
        test_encode_key();
        test_config_side_effects();
        test_decode_groups();
        test_output_backpressure();
        test_random_encode();
        test_random_decode();
        test_full_rate();

        drain_results();
        $display("Sent %0d items in %0d messages, %0d register writes; checked %0d results.",
                 items_sent, msgs_sent, cfg_writes, results_seen);
        $display("Both directions, padding, short ends, %0d bad-char results, output hold-off.",
                 bad_results);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
